// ===== rtl/core/sfcs_pkg.sv =====
// Shared types, register defaults and helper functions of the serial flash command sequencer.
package sfcs_pkg;

   // Default number of extra status polls an erase may spend.
   localparam int POLL_LIMIT_DEFAULT = 16777216;

   // Depth of the result word queue in front of the response port.
   localparam int QUEUE_DEPTH = 4;

   // Dummy byte on the serial link, and the opcode value that means no write enable.
   localparam logic [7:0] DUMMY_BYTE = 8'hA5;
   localparam logic [7:0] NO_OPCODE  = 8'hFF;

   // Request operations; also used to remember the running command.
   typedef enum logic [2:0] {
      OP_RX       = 3'd0,
      OP_READ_ID  = 3'd1,
      OP_PROG     = 3'd2,
      OP_PDATA    = 3'd3,
      OP_READ     = 3'd4,
      OP_ERASE    = 3'd5,
      OP_STATUS   = 3'd6,
      OP_NONE     = 3'd7
   } op_type;

   // Kinds of result words.
   typedef enum logic [1:0] {
      KIND_TX     = 2'd0,
      KIND_ID     = 2'd1,
      KIND_DATA   = 2'd2,
      KIND_STATUS = 2'd3
   } kind_type;

   // Status report codes.
   typedef enum logic [1:0] {
      STAT_READY   = 2'd0,
      STAT_BUSY    = 2'd1,
      STAT_TIMEOUT = 2'd2
   } status_type;

   // Sequencer phases.
   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_WREN  = 4'd1,
      PH_OPC   = 4'd2,
      PH_AHI   = 4'd3,
      PH_AMID  = 4'd4,
      PH_ALO   = 4'd5,
      PH_PWAIT = 4'd6,
      PH_PDATA = 4'd7,
      PH_PRE   = 4'd8,
      PH_DATA  = 4'd9,
      PH_SOPC  = 4'd10,
      PH_SVAL  = 4'd11
   } phase_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_PAGE_SHIFT   = 3'd0,
      CSR_READ_OPC     = 3'd1,
      CSR_ID_OPC       = 3'd2,
      CSR_PROGRAM_OPC  = 3'd3,
      CSR_WREN_OPC     = 3'd4,
      CSR_ERASE_OPC    = 3'd5,
      CSR_STATUS_OPC   = 3'd6,
      CSR_BUSY_SELECT  = 3'd7
   } csr_index_type;

   // Configuration register set.
   typedef struct packed {
      logic [4:0] page_shift;
      logic [7:0] read_opcode;
      logic [7:0] id_opcode;
      logic [7:0] program_opcode;
      logic [7:0] write_enable_opcode;
      logic [7:0] erase_opcode;
      logic [7:0] status_opcode;
      logic [3:0] busy_select;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      page_shift:          5'd8,
      read_opcode:         8'h03,
      id_opcode:           8'h9F,
      program_opcode:      8'h02,
      write_enable_opcode: 8'h06,
      erase_opcode:        8'hD8,
      status_opcode:       8'h05,
      busy_select:         4'd8
   };

   // One request word.
   typedef struct packed {
      op_type      op;
      logic [23:0] page;
      logic [15:0] offset;
      logic [15:0] count_less_one;
      logic [7:0]  data_byte;
      logic        final_data;
   } req_item_type;

   // One result word.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  tx_byte;
      logic        release_select;
      logic [7:0]  host_byte;
      status_type  status_code;
      logic        last;
   } rsp_item_type;

   // Command byte of an addressed command or read ID.
   function automatic logic [7:0] opcode_of(input cfg_type cfg, input op_type ck);
      logic [7:0] opc;
      case (ck)
         OP_PROG:  opc = cfg.program_opcode;
         OP_ERASE: opc = cfg.erase_opcode;
         OP_READ:  opc = cfg.read_opcode;
         default:  opc = cfg.id_opcode;
      endcase
      return opc;
   endfunction

   // Transmit word.
   function automatic rsp_item_type tx_word(input logic [7:0] b, input logic rel);
      rsp_item_type r;
      r                = '0;
      r.kind           = KIND_TX;
      r.tx_byte        = b;
      r.release_select = rel;
      return r;
   endfunction

endpackage

// ===== rtl/core/spi_flash_command_sequencer.sv =====
// Top level of the serial flash command sequencer: ports, registers, input stage and result queue.
//
// The sequencer takes request words and answers each with zero, one or two result words. A
// request is handled in one pass of logic between the input register and a four-word result
// queue, so its first result passes through the input register and then the queue before it
// reaches the response port. The request side stalls only while a word waits in the input
// register and more than two result words sit in the queue. With a response side that is always
// ready, words that cause at most one result each flow at one per cycle, while a run of words
// that each cause two results is held back by the one-word-per-cycle response port. In use the
// rate is set by the serial link, one byte exchange per received-byte word. Every transmit
// result must be answered by exactly one received-byte word before the command moves on.
// Configuration registers may only be written while no command runs.
module spi_flash_command_sequencer #(
   parameter int POLL_LIMIT = sfcs_pkg::POLL_LIMIT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // page[23:0], offset[39:24], count_less_one[55:40],
                                    // data_byte[63:56]
   input  logic [2:0]  req_tuser,   // op[2:0]
   input  logic        req_tlast,   // final_data
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // tx_byte[7:0], release_select[8], host_byte[16:9],
                                    // status_code[18:17], zero[23:19]
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast,   // last
   // Configuration writes.
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import sfcs_pkg::*;

   localparam int CountW = $clog2(QUEUE_DEPTH + 1);

   cfg_type      cfg_ff, cfg_in;
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   rsp_item_type q_ff [QUEUE_DEPTH];
   rsp_item_type q_in [QUEUE_DEPTH];
   logic [CountW-1:0] count_ff, count_in, base;
   logic         process, pop, accept;
   logic [1:0]   res_count;
   rsp_item_type res0, res1;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PAGE_SHIFT:  cfg_in.page_shift          = csr_wdata[4:0];
            CSR_READ_OPC:    cfg_in.read_opcode         = csr_wdata;
            CSR_ID_OPC:      cfg_in.id_opcode           = csr_wdata;
            CSR_PROGRAM_OPC: cfg_in.program_opcode      = csr_wdata;
            CSR_WREN_OPC:    cfg_in.write_enable_opcode = csr_wdata;
            CSR_ERASE_OPC:   cfg_in.erase_opcode        = csr_wdata;
            CSR_STATUS_OPC:  cfg_in.status_opcode       = csr_wdata;
            CSR_BUSY_SELECT: cfg_in.busy_select         = csr_wdata[3:0];
            default:         cfg_in                     = cfg_ff;
         endcase
      end
   end

   // The held word is processed when the queue has room for two results.
   assign process    = in_valid_ff && (count_ff <= CountW'(QUEUE_DEPTH - 2));
   assign req_tready = !in_valid_ff || process;
   assign accept     = req_tvalid && req_tready;
   assign pop        = (count_ff != '0) && rsp_tready;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (accept) begin
         in_valid_in               = 1'b1;
         in_item_in.op             = op_type'(req_tuser);
         in_item_in.page           = req_tdata[23:0];
         in_item_in.offset         = req_tdata[39:24];
         in_item_in.count_less_one = req_tdata[55:40];
         in_item_in.data_byte      = req_tdata[63:56];
         in_item_in.final_data     = req_tlast;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   sfcs_engine #(
      .POLL_LIMIT (POLL_LIMIT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .enable    (process),
      .cfg       (cfg_ff),
      .item      (in_item_ff),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1)
   );

   // Result queue: the head sits at entry zero, new words land behind the last one.
   assign base = count_ff - CountW'(pop);
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_in[i] = q_ff[i];
         if (pop) begin
            q_in[i] = q_ff[(i + 1 < QUEUE_DEPTH) ? i + 1 : i];
         end
         if (process && res_count != 2'd0 && CountW'(i) == base) begin
            q_in[i] = res0;
         end
         if (process && res_count == 2'd2 && CountW'(i) == base + CountW'(1)) begin
            q_in[i] = res1;
         end
      end
      count_in = base + (process ? CountW'(res_count) : '0);
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= CFG_RESET;
         in_valid_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
         count_ff    <= count_in;
      end
      in_item_ff <= in_item_in;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   // Response port driven from the queue head.
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tuser  = q_ff[0].kind;
   assign rsp_tlast  = q_ff[0].last;
   assign rsp_tdata  = {5'd0, q_ff[0].status_code, q_ff[0].host_byte,
                        q_ff[0].release_select, q_ff[0].tx_byte};

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(QUEUE_DEPTH))
      else $error("result queue count beyond its depth");

   a_held_word: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !process |=> in_valid_ff && $stable(in_item_ff))
      else $error("unprocessed request word was lost or changed");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      process && res_count == 2'd2 |->
         (res0.kind == KIND_ID || res0.kind == KIND_DATA) && res1.kind == KIND_TX)
      else $error("a result pair must be a host byte followed by a transmit byte");
`endif

endmodule

// ===== rtl/core/sfcs_engine.sv =====
// Sequencer state and the per-word decision logic that turns one request word into results.
module sfcs_engine #(
   parameter int POLL_LIMIT = sfcs_pkg::POLL_LIMIT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  sfcs_pkg::cfg_type      cfg,
   input  sfcs_pkg::req_item_type item,
   output logic [1:0]             res_count,
   output sfcs_pkg::rsp_item_type res0,
   output sfcs_pkg::rsp_item_type res1
);
   import sfcs_pkg::*;

   localparam int PollW = $clog2(POLL_LIMIT + 2);

   phase_type        phase_ff, phase_in;
   logic [16:0]      byte_counter_ff, byte_counter_in;
   logic [23:0]      address_ff, address_in;
   logic [PollW-1:0] polls_left_ff, polls_left_in;
   op_type           command_ff, command_in;

   logic [23:0]      new_address;
   logic [16:0]      bc_dec;
   logic [PollW-1:0] polls_dec;
   logic             busy;

   // Byte address of the request: shifted page, plus offset for a read, low 24 bits.
   always_comb begin
      new_address = 24'(item.page << cfg.page_shift);
      if (item.op == OP_READ) begin
         new_address = new_address + {8'd0, item.offset};
      end
   end

   assign bc_dec    = byte_counter_ff - 17'd1;
   assign polls_dec = (polls_left_ff != '0) ? polls_left_ff - PollW'(1) : polls_left_ff;
   assign busy      = (item.data_byte[cfg.busy_select[2:0]] == cfg.busy_select[3]);

   // Next state and result words for the word at the input register.
   always_comb begin
      phase_in        = phase_ff;
      byte_counter_in = byte_counter_ff;
      address_in      = address_ff;
      polls_left_in   = polls_left_ff;
      command_in      = command_ff;
      res_count       = 2'd0;
      res0            = '0;
      res1            = '0;
      if (item.op == OP_RX) begin
         unique case (phase_ff)
            PH_WREN: begin
               res0      = tx_word(opcode_of(cfg, command_ff), 1'b0);
               res_count = 2'd1;
               phase_in  = PH_OPC;
            end
            PH_OPC: begin
               res_count = 2'd1;
               if (command_ff == OP_READ_ID) begin
                  byte_counter_in = 17'd4;
                  res0            = tx_word(DUMMY_BYTE, 1'b0);
                  phase_in        = PH_DATA;
               end else begin
                  res0     = tx_word(address_ff[23:16], 1'b0);
                  phase_in = PH_AHI;
               end
            end
            PH_AHI: begin
               res0      = tx_word(address_ff[15:8], 1'b0);
               res_count = 2'd1;
               phase_in  = PH_AMID;
            end
            PH_AMID: begin
               res0      = tx_word(address_ff[7:0], command_ff == OP_ERASE);
               res_count = 2'd1;
               phase_in  = PH_ALO;
            end
            PH_ALO: begin
               if (command_ff == OP_PROG) begin
                  phase_in = PH_PWAIT;
               end else if (command_ff == OP_READ) begin
                  res0      = tx_word(DUMMY_BYTE, 1'b0);
                  res_count = 2'd1;
                  phase_in  = PH_PRE;
               end else begin
                  res0      = tx_word(cfg.status_opcode, 1'b0);
                  res_count = 2'd1;
                  phase_in  = PH_SOPC;
               end
            end
            PH_PDATA: begin
               // The final data byte closes the program; otherwise wait for more.
               phase_in        = (byte_counter_ff != '0) ? PH_IDLE : PH_PWAIT;
               byte_counter_in = '0;
            end
            PH_PRE: begin
               res0      = tx_word(DUMMY_BYTE, byte_counter_ff == 17'd1);
               res_count = 2'd1;
               phase_in  = PH_DATA;
            end
            PH_DATA: begin
               res0.kind      = (command_ff == OP_READ_ID) ? KIND_ID : KIND_DATA;
               res0.host_byte = item.data_byte;
               if (byte_counter_ff <= 17'd1) begin
                  res0.last       = 1'b1;
                  res_count       = 2'd1;
                  byte_counter_in = '0;
                  phase_in        = PH_IDLE;
               end else begin
                  // Hand the byte over and clock in the next one.
                  byte_counter_in = bc_dec;
                  res1            = tx_word(DUMMY_BYTE, bc_dec == 17'd1);
                  res_count       = 2'd2;
               end
            end
            PH_SOPC: begin
               res0      = tx_word(DUMMY_BYTE, 1'b1);
               res_count = 2'd1;
               phase_in  = PH_SVAL;
            end
            PH_SVAL: begin
               res_count = 2'd1;
               if (command_ff == OP_ERASE) begin
                  polls_left_in = polls_dec;
                  if (busy && polls_dec != '0) begin
                     res0     = tx_word(cfg.status_opcode, 1'b0);
                     phase_in = PH_SOPC;
                  end else begin
                     res0.kind        = KIND_STATUS;
                     res0.status_code = (polls_dec == '0) ? STAT_TIMEOUT : STAT_READY;
                     res0.last        = 1'b1;
                     phase_in         = PH_IDLE;
                  end
               end else begin
                  res0.kind        = KIND_STATUS;
                  res0.status_code = busy ? STAT_BUSY : STAT_READY;
                  res0.last        = 1'b1;
                  phase_in         = PH_IDLE;
               end
            end
            default: begin
               // No exchange outstanding: a stray received byte is dropped.
            end
         endcase
      end else if (item.op == OP_PDATA) begin
         if (phase_ff == PH_PWAIT) begin
            byte_counter_in = {16'd0, item.final_data};
            res0            = tx_word(item.data_byte, item.final_data);
            res_count       = 2'd1;
            phase_in        = PH_PDATA;
         end
      end else if (phase_ff == PH_IDLE && item.op != OP_NONE) begin
         // A new host command starts.
         command_in      = item.op;
         byte_counter_in = '0;
         res_count       = 2'd1;
         case (item.op)
            OP_READ_ID: begin
               res0     = tx_word(cfg.id_opcode, 1'b0);
               phase_in = PH_OPC;
            end
            OP_READ: begin
               address_in      = new_address;
               byte_counter_in = {1'b0, item.count_less_one} + 17'd1;
               res0            = tx_word(cfg.read_opcode, 1'b0);
               phase_in        = PH_OPC;
            end
            OP_STATUS: begin
               res0     = tx_word(cfg.status_opcode, 1'b0);
               phase_in = PH_SOPC;
            end
            default: begin
               address_in = new_address;
               if (item.op == OP_ERASE) begin
                  polls_left_in = PollW'(POLL_LIMIT + 1);
               end
               if (cfg.write_enable_opcode != NO_OPCODE) begin
                  res0     = tx_word(cfg.write_enable_opcode, 1'b1);
                  phase_in = PH_WREN;
               end else begin
                  res0     = tx_word(opcode_of(cfg, item.op), 1'b0);
                  phase_in = PH_OPC;
               end
            end
         endcase
      end
   end

   // State registers advance only when a word is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         byte_counter_ff <= '0;
         address_ff      <= '0;
         polls_left_ff   <= '0;
         command_ff      <= OP_RX;
      end else if (enable) begin
         phase_ff        <= phase_in;
         byte_counter_ff <= byte_counter_in;
         address_ff      <= address_in;
         polls_left_ff   <= polls_left_in;
         command_ff      <= command_in;
      end
   end

endmodule
